// ===== design/welford_mean_ci_tracker_unit_assert.svh =====
// Assertion macros used by the tracker controller.
`ifndef WELFORD_MEAN_CI_TRACKER_UNIT_ASSERT_SVH
`define WELFORD_MEAN_CI_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define WMCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmct assertion failed");
// Next-cycle implication.
`define WMCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmct assertion failed");
`else
`define WMCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WMCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/wmct_pkg.sv =====
`default_nettype none
package wmct_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int MIN_SAMPLES = 30;
    localparam int DIV_W       = 80;
    localparam int DIV_CNT_W   = 7;

    // Divider operand selection.
    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_VAR  = 2'd1;
    localparam logic [1:0] DIV_HW   = 2'd2;

    // Configuration register indexes.
    localparam logic REG_QUANTILE  = 1'b0;
    localparam logic REG_STABILITY = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       div_go;
        logic [1:0] div_sel;
        logic       mean_upd;
        logic       mul_en;
        logic [1:0] mul_step;
        logic       m2_upd;
        logic       var_upd;
        logic       sqrt_go;
        logic       scale;
        logic       out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic n_ge2;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/welford_mean_ci_tracker_unit.sv =====
`default_nettype none
// Channel  | Direction | Handshake                     | Payload
// input    | in        | i_in_valid / o_in_stall       | i_sample
// output   | out       | o_out_valid / i_out_stall     | o_mean .. o_overflow
// config   | in        | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Each sample runs from acceptance to result through the bit-serial divider, shared
// by the mean, variance and standard-error divisions, and then a bit-serial root;
// the variance division is skipped while fewer than two samples have arrived.
// Reset is synchronous and active low and clears all statistics at once.
// A stalled result is held in the output register while the next sample runs;
// only the final load waits for the output side.
module welford_mean_ci_tracker_unit
    import wmct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_sample,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_mean,
    output logic [63:0]      o_variance,
    output logic [31:0]      o_half_width,
    output logic [31:0]      o_sample_count,
    output logic             o_enough_samples,
    output logic             o_overflow,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [23:0] r_quantile;
    logic        r_req_stab;
    logic        w_wr;
    t_cmd        w_cmd;
    t_sts        w_sts;

    // Configuration registers.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantile <= 24'd128451;
            r_req_stab <= 1'b0;
        end else if (w_wr) begin
            if (paddr[2] == REG_QUANTILE) begin
                r_quantile <= pwdata[23:0];
            end else begin
                r_req_stab <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_STABILITY) ? {31'd0, r_req_stab} : {8'd0, r_quantile};

    wmct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    wmct_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_sample            (i_sample),
        .i_quantile          (r_quantile),
        .i_require_stability (r_req_stab),
        .o_sts               (w_sts),
        .o_mean              (o_mean),
        .o_variance          (o_variance),
        .o_half_width        (o_half_width),
        .o_sample_count      (o_sample_count),
        .o_enough_samples    (o_enough_samples),
        .o_overflow          (o_overflow)
    );

endmodule
`default_nettype wire

// ===== design/wmct_div.sv =====
`default_nettype none
module wmct_div
    import wmct_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_W-1:0]     i_dividend,
    input  wire logic [31:0]          i_divisor,
    input  wire logic [DIV_CNT_W-1:0] i_iters,
    output logic                      o_done,
    output logic [DIV_W-1:0]          o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_sh, n_sh;
    logic [31:0]          r_rem, n_rem;
    logic [31:0]          r_dsr, n_dsr;
    logic [32:0]          w_trial;
    logic [32:0]          w_diff;
    logic                 w_ge;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_sh[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_iters;
            n_sh   = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_sh  = {r_sh[DIV_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[31:0] : w_trial[31:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule
`default_nettype wire

// ===== design/wmct_dp.sv =====
`default_nettype none
module wmct_dp
    import wmct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_sample,
    input  wire logic [23:0] i_quantile,
    input  wire logic        i_require_stability,
    output t_sts             o_sts,
    output logic [31:0]      o_mean,
    output logic [63:0]      o_variance,
    output logic [31:0]      o_half_width,
    output logic [31:0]      o_sample_count,
    output logic             o_enough_samples,
    output logic             o_overflow
);

    logic signed [47:0]   r_x;
    logic signed [47:0]   r_mean;
    logic signed [47:0]   r_prev;
    logic [48:0]          r_dabs;
    logic                 r_dneg;
    logic [97:0]          r_prod;
    logic [63:0]          r_m2;
    logic [63:0]          r_var;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                 r_ovf;
    logic [63:0]          r_rad;
    logic [31:0]          r_srem;
    logic [31:0]          r_root;
    logic [5:0]           r_scnt;
    logic                 r_sbusy;
    logic                 r_sdone;
    logic [31:0]          r_hw;

    logic [48:0]          w_delta;
    logic [48:0]          w_dabs;
    logic                 w_div_done;
    logic [DIV_W-1:0]     w_quot;
    logic [DIV_W-1:0]     w_dividend;
    logic [31:0]          w_divisor;
    logic [DIV_CNT_W-1:0] w_iters;
    logic [31:0]          w_op_a, w_op_b;
    logic [63:0]          w_pp;
    logic [97:0]          w_pp_ext;
    logic [64:0]          w_m2_sum;
    logic [33:0]          w_sq_sh, w_sq_trial, w_sq_diff;
    logic                 w_sq_ge;
    logic [55:0]          w_scl;
    logic [48:0]          w_mdiff, w_mabs;
    logic [55:0]          w_d100;
    logic                 w_stable;
    logic                 w_enough;

    // Difference of sample and mean; before the mean update it is delta,
    // after it the post-update deviation.
    assign w_delta = {r_x[47], r_x} - {r_mean[47], r_mean};
    assign w_dabs  = w_delta[48] ? (49'd0 - w_delta) : w_delta;

    // Operand setup for the shared divider.
    always_comb begin
        case (i_cmd.div_sel)
            DIV_MEAN: begin
                w_dividend = {w_dabs, 31'd0};
                w_divisor  = r_count;
                w_iters    = DIV_CNT_W'(49);
            end
            DIV_VAR: begin
                w_dividend = {r_m2, 16'd0};
                w_divisor  = r_count - 32'd1;
                w_iters    = DIV_CNT_W'(80);
            end
            DIV_HW: begin
                w_dividend = {r_var, 16'd0};
                w_divisor  = r_count;
                w_iters    = DIV_CNT_W'(64);
            end
            default: begin
                w_dividend = '0;
                w_divisor  = r_count;
                w_iters    = DIV_CNT_W'(1);
            end
        endcase
    end

    wmct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_iters    (w_iters),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Partial products of |delta| * |after|, one 32x32 product per step.
    always_comb begin
        case (i_cmd.mul_step)
            2'd0: begin
                w_op_a = r_dabs[31:0];
                w_op_b = w_dabs[31:0];
            end
            2'd1: begin
                w_op_a = r_dabs[31:0];
                w_op_b = {15'd0, w_dabs[48:32]};
            end
            2'd2: begin
                w_op_a = {15'd0, r_dabs[48:32]};
                w_op_b = w_dabs[31:0];
            end
            default: begin
                w_op_a = {15'd0, r_dabs[48:32]};
                w_op_b = {15'd0, w_dabs[48:32]};
            end
        endcase
    end

    assign w_pp = w_op_a * w_op_b;

    always_comb begin
        case (i_cmd.mul_step)
            2'd0:    w_pp_ext = {34'd0, w_pp};
            2'd1:    w_pp_ext = {2'd0, w_pp, 32'd0};
            2'd2:    w_pp_ext = {2'd0, w_pp, 32'd0};
            default: w_pp_ext = {w_pp[33:0], 64'd0};
        endcase
    end

    // Saturating M2 accumulate of the Q.32 product shifted down by 48 bits.
    assign w_m2_sum = {1'b0, r_m2} + {15'd0, r_prod[97:48]};

    // Square root, one result bit per cycle.
    assign w_sq_sh    = {r_srem, r_rad[63:62]};
    assign w_sq_trial = {r_root, 2'b01};
    assign w_sq_ge    = (w_sq_sh >= w_sq_trial);
    assign w_sq_diff  = w_sq_sh - w_sq_trial;

    // Quantile scaling of the standard error.
    assign w_scl = r_root * i_quantile;

    // Stability test: 100*|previous - mean| < mean.
    assign w_mdiff  = {r_prev[47], r_prev} - {r_mean[47], r_mean};
    assign w_mabs   = w_mdiff[48] ? (49'd0 - w_mdiff) : w_mdiff;
    assign w_d100   = ({7'd0, w_mabs} << 6) + ({7'd0, w_mabs} << 5) + ({7'd0, w_mabs} << 2);
    assign w_stable = !r_mean[47] && ({8'd0, r_mean} > w_d100);
    assign w_enough = (r_count >= COUNT_WIDTH'(MIN_SAMPLES))
                      && (!i_require_stability || w_stable);

    // Running statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_prev  <= '0;
            r_m2    <= '0;
            r_var   <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                if (r_count == '1) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.div_go && (i_cmd.div_sel == DIV_MEAN)) begin
                r_prev <= r_mean;
            end
            if (i_cmd.mean_upd) begin
                if (r_dneg) begin
                    r_mean <= r_mean - signed'(w_quot[47:0]);
                end else begin
                    r_mean <= r_mean + signed'(w_quot[47:0]);
                end
            end
            if (i_cmd.m2_upd) begin
                if (w_m2_sum[64]) begin
                    r_m2  <= '1;
                    r_ovf <= 1'b1;
                end else begin
                    r_m2 <= w_m2_sum[63:0];
                end
            end
            if (i_cmd.var_upd) begin
                r_var <= (|w_quot[79:64]) ? '1 : w_quot[63:0];
            end
        end
    end

    // Sample capture, delta and product registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= {i_sample, 16'd0};
        end
        if (i_cmd.div_go && (i_cmd.div_sel == DIV_MEAN)) begin
            r_dabs <= w_dabs;
            r_dneg <= w_delta[48];
        end
        if (i_cmd.mul_en) begin
            r_prod <= (i_cmd.mul_step == 2'd0) ? w_pp_ext : (r_prod + w_pp_ext);
        end
        if (i_cmd.scale) begin
            r_hw <= (|w_scl[55:48]) ? '1 : w_scl[47:16];
        end
    end

    // Square root sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
            r_scnt  <= '0;
        end else begin
            r_sdone <= 1'b0;
            if (i_cmd.sqrt_go) begin
                r_sbusy <= 1'b1;
                r_scnt  <= 6'd32;
            end else if (r_sbusy) begin
                r_scnt <= r_scnt - 1'b1;
                if (r_scnt == 6'd1) begin
                    r_sbusy <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
        end
        if (i_cmd.sqrt_go) begin
            r_rad  <= w_quot[63:0];
            r_srem <= '0;
            r_root <= '0;
        end else if (r_sbusy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_srem <= w_sq_ge ? w_sq_diff[31:0] : w_sq_sh[31:0];
            r_root <= {r_root[30:0], w_sq_ge};
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_mean           <= r_mean[47:16];
            o_variance       <= r_var;
            o_half_width     <= r_hw;
            o_sample_count   <= r_count;
            o_enough_samples <= w_enough;
            o_overflow       <= r_ovf;
        end
    end

    assign o_sts.div_done  = w_div_done;
    assign o_sts.sqrt_done = r_sdone;
    assign o_sts.n_ge2     = (r_count >= COUNT_WIDTH'(2));

endmodule
`default_nettype wire

// ===== design/wmct_ctrl.sv =====
`default_nettype none
`include "welford_mean_ci_tracker_unit_assert.svh"
module wmct_ctrl
    import wmct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_stall,
    output logic      o_out_valid
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DMGO  = 4'd1;
    localparam logic [3:0] ST_DMWT  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_M2    = 4'd4;
    localparam logic [3:0] ST_DVGO  = 4'd5;
    localparam logic [3:0] ST_DVWT  = 4'd6;
    localparam logic [3:0] ST_DHGO  = 4'd7;
    localparam logic [3:0] ST_DHWT  = 4'd8;
    localparam logic [3:0] ST_SQWT  = 4'd9;
    localparam logic [3:0] ST_SCALE = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencing of one sample through the datapath.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DMGO;
                end
            end
            ST_DMGO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_MEAN;
                n_state       = ST_DMWT;
            end
            ST_DMWT: begin
                if (i_sts.div_done) begin
                    o_cmd.mean_upd = 1'b1;
                    n_step         = 2'd0;
                    n_state        = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_step = r_step;
                n_step         = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = ST_M2;
                end
            end
            ST_M2: begin
                o_cmd.m2_upd = 1'b1;
                n_state      = ST_DVGO;
            end
            ST_DVGO: begin
                if (i_sts.n_ge2) begin
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_sel = DIV_VAR;
                    n_state       = ST_DVWT;
                end else begin
                    n_state = ST_DHGO;
                end
            end
            ST_DVWT: begin
                if (i_sts.div_done) begin
                    o_cmd.var_upd = 1'b1;
                    n_state       = ST_DHGO;
                end
            end
            ST_DHGO: begin
                o_cmd.div_go  = 1'b1;
                o_cmd.div_sel = DIV_HW;
                n_state       = ST_DHWT;
            end
            ST_DHWT: begin
                if (i_sts.div_done) begin
                    o_cmd.sqrt_go = 1'b1;
                    n_state       = ST_SQWT;
                end
            end
            ST_SQWT: begin
                if (i_sts.sqrt_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // A captured sample always starts the mean division next.
    `WMCT_ASSERT_NXT(a_capture_to_div, i_clk, i_rst_n, o_cmd.capture, r_state == ST_DMGO)
    // The product takes exactly four steps before the M2 update.
    `WMCT_ASSERT_NXT(a_mul_to_m2, i_clk, i_rst_n,
        (r_state == ST_MUL) && (r_step == 2'd3), r_state == ST_M2)
    // A result is never loaded over one that is still stalled.
    `WMCT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_ld,
        !(r_out_valid && i_out_stall))

endmodule
`default_nettype wire
